### src/irmt_pkg.sv
`default_nettype none
package irmt_pkg;

	localparam int MAX_EXTENTS_DEF = 8;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] OVERFLOW_RST = 32'd65534;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_MAP_UP   = 2'd1,
		OP_MAP_DOWN = 2'd2,
		OP_CLEAR    = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OVERLAP   = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_e;

	typedef struct packed {
		op_e         opcode;
		logic [31:0] query_id;
		logic [31:0] upper_first;
		logic [31:0] lower_first;
		logic [31:0] range_count;
	} req_t;

	typedef struct packed {
		status_e     status;
		logic [31:0] mapped_id;
		logic [31:0] munged_id;
		logic [3:0]  extent_total;
	} rsp_t;

	// request token walking the cell chain
	typedef struct packed {
		logic        vld;
		op_e         op;
		logic [31:0] a;
		logic [31:0] a_end;
		logic [31:0] b;
		logic [31:0] b_end;
		logic        bad;
		logic        hit;
		logic [31:0] res;
	} tok_t;

	// one stored extent, ends precomputed, delta = upper - lower
	typedef struct packed {
		logic [31:0] u_first;
		logic [31:0] u_last;
		logic [31:0] l_first;
		logic [31:0] l_last;
		logic [31:0] delta;
	} ext_t;

endpackage
`default_nettype wire

### src/irmt_cell.sv
`default_nettype none
module irmt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire irmt_pkg::tok_t   tok_in,
	output irmt_pkg::tok_t        tok_out,
	input  wire logic [CNT_W-1:0] entry_count,
	input  wire logic             wr_en,
	input  wire irmt_pkg::ext_t   wr_data
);
	import irmt_pkg::*;

	ext_t ext_q;
	tok_t tok_q;
	tok_t tok_nxt;
	logic live;
	logic cell_hit;
	logic [31:0] cell_res;

	assign live = CNT_W'(IDX) < entry_count;

	always_ff @(posedge clk) begin
		if (wr_en && entry_count == CNT_W'(IDX)) begin
			ext_q <= wr_data;
		end
	end

	always_comb begin
		cell_hit = 1'b0;
		cell_res = tok_in.a + ext_q.delta;
		unique case (tok_in.op)
			OP_INSERT: begin
				cell_hit = (ext_q.u_first <= tok_in.a_end && ext_q.u_last >= tok_in.a) ||
					(ext_q.l_first <= tok_in.b_end && ext_q.l_last >= tok_in.b);
			end
			OP_MAP_UP: begin
				cell_hit = tok_in.a >= ext_q.l_first && tok_in.a <= ext_q.l_last;
				cell_res = tok_in.a + ext_q.delta;
			end
			OP_MAP_DOWN: begin
				cell_hit = tok_in.a >= ext_q.u_first && tok_in.a <= ext_q.u_last &&
					tok_in.a_end >= ext_q.u_first && tok_in.a_end <= ext_q.u_last;
				cell_res = tok_in.a - ext_q.delta;
			end
			OP_CLEAR: begin
				cell_hit = 1'b0;
			end
			default: begin
				cell_hit = 1'b0;
			end
		endcase
		tok_nxt = tok_in;
		if (live && cell_hit && !tok_in.hit) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.res = cell_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

### src/id_range_map_table.sv
// A request is accepted when start is high and busy is low; it is registered at
// the head and walks the cell chain one extent per cycle, and busy stays high
// until done, so no new request is accepted while one is in flight.
// Reset: table empty, overflow_id = 65534; extent words are unset until inserted.
// The receiver cannot stall: each result is shown on done for one cycle.
`default_nettype none
module id_range_map_table #(
	parameter int MAX_EXTENTS = irmt_pkg::MAX_EXTENTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire irmt_pkg::req_t request,
	output logic                done,
	output irmt_pkg::rsp_t      result,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata
);
	import irmt_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

	logic [CNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic [31:0] overflow_q;
	logic busy_q;
	logic done_q;
	rsp_t result_q;
	tok_t tok0_q;
	tok_t tok_head;
	tok_t chain [0:MAX_EXTENTS];
	tok_t tok_end;
	logic [32:0] sum_u;
	logic [32:0] sum_l;
	logic wr_en;
	ext_t wr_data;
	status_e st;
	logic [31:0] mapped;
	logic [31:0] munged;
	logic [CNT_W+3:0] tot_ext;

	assign sum_u = {1'b0, request.upper_first} + {1'b0, request.range_count};
	assign sum_l = {1'b0, request.lower_first} + {1'b0, request.range_count};

	always_comb begin
		tok_head       = '0;
		tok_head.vld   = start && !busy_q;
		tok_head.op    = request.opcode;
		tok_head.a     = request.query_id;
		tok_head.a_end = request.query_id;
		unique case (request.opcode)
			OP_INSERT: begin
				tok_head.a     = request.upper_first;
				tok_head.a_end = sum_u[31:0] - 32'd1;
				tok_head.b     = request.lower_first;
				tok_head.b_end = sum_l[31:0] - 32'd1;
				tok_head.bad   = request.upper_first == ALL_ONES ||
					request.lower_first == ALL_ONES || request.range_count == '0 ||
					sum_u[32] || sum_l[32];
			end
			OP_MAP_DOWN: begin
				tok_head.a_end = request.query_id + request.range_count - 32'd1;
			end
			OP_MAP_UP, OP_CLEAR: begin
				tok_head.a_end = request.query_id;
			end
			default: begin
				tok_head.a_end = request.query_id;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q.vld <= 1'b0;
		end else begin
			tok0_q <= tok_head;
		end
	end

	assign chain[0] = tok0_q;

	for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
		irmt_cell #(
			.IDX  (k),
			.CNT_W(CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (chain[k]),
			.tok_out    (chain[k+1]),
			.entry_count(entry_count_q),
			.wr_en      (wr_en),
			.wr_data    (wr_data)
		);
	end

	assign tok_end = chain[MAX_EXTENTS];

	always_comb begin
		st      = ST_OK;
		mapped  = '0;
		munged  = '0;
		wr_en   = 1'b0;
		cnt_nxt = entry_count_q;
		unique case (tok_end.op)
			OP_INSERT: begin
				priority if (tok_end.bad) begin
					st = ST_INVALID;
				end else if (tok_end.hit) begin
					st = ST_OVERLAP;
				end else if (entry_count_q >= CNT_W'(MAX_EXTENTS)) begin
					st = ST_FULL;
				end else begin
					wr_en   = tok_end.vld;
					cnt_nxt = entry_count_q + CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				cnt_nxt = '0;
			end
			OP_MAP_UP, OP_MAP_DOWN: begin
				if (tok_end.hit) begin
					mapped = tok_end.res;
					munged = tok_end.res;
				end else begin
					st     = ST_NOT_FOUND;
					mapped = ALL_ONES;
					munged = overflow_q;
				end
			end
			default: begin
				cnt_nxt = entry_count_q;
			end
		endcase
		tot_ext = {4'b0000, cnt_nxt};
	end

	assign wr_data.u_first = tok_end.a;
	assign wr_data.u_last  = tok_end.a_end;
	assign wr_data.l_first = tok_end.b;
	assign wr_data.l_last  = tok_end.b_end;
	assign wr_data.delta   = tok_end.a - tok_end.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			entry_count_q <= '0;
			overflow_q    <= OVERFLOW_RST;
		end else begin
			done_q <= tok_end.vld;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (tok_end.vld) begin
				busy_q <= 1'b0;
			end
			if (tok_end.vld) begin
				entry_count_q <= cnt_nxt;
			end
			if (cfg_we) begin
				overflow_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.vld) begin
			result_q.status       <= st;
			result_q.mapped_id    <= mapped;
			result_q.munged_id    <= munged;
			result_q.extent_total <= tot_ext[3:0];
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### src/irmt_chk.sv
`default_nettype none
module irmt_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire irmt_pkg::rsp_t result
);
	import irmt_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without request in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result for one request");

	a_not_found_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_NOT_FOUND |-> result.mapped_id == ALL_ONES)
		else $error("failed mapping without all-ones id");

endmodule

bind id_range_map_table irmt_chk u_irmt_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
`default_nettype wire
